// ===== rtl/pse_pkg.sv =====
// ----------------------------------------------------------------------------
// pse_pkg
// Shared widths, opcode and status codes, and the ALU response bundle for the
// postfix stack evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package pse_pkg;

  localparam int DATA_W              = 32;
  localparam int NUM_W               = 31;
  localparam int OPC_W               = 3;
  localparam int STATUS_W            = 2;
  localparam int DEPTH_W             = 7;
  localparam int DEFAULT_STACK_DEPTH = 64;

  typedef logic [DATA_W-1:0]   word_t;
  typedef logic [OPC_W-1:0]    opcode_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam opcode_t OP_PUSH = 3'd0;
  localparam opcode_t OP_ADD  = 3'd1;
  localparam opcode_t OP_SUB  = 3'd2;
  localparam opcode_t OP_DIV  = 3'd3;
  localparam opcode_t OP_MUL  = 3'd4;
  localparam opcode_t OP_REM  = 3'd5;
  localparam opcode_t OP_XOR  = 3'd6;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_UNDER = 2'd1;
  localparam status_t ST_OVER  = 2'd2;
  localparam status_t ST_DIVZ  = 2'd3;

  typedef struct packed {
    logic  done;
    logic  div_zero;
    word_t result;
  } alu_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/postfix_stack_evaluator.sv =====
// ----------------------------------------------------------------------------
// postfix_stack_evaluator
// Postfix integer expression evaluator on an operand stack in RAM.
// ----------------------------------------------------------------------------
// One token is taken per in beat and the block is busy until it is done. A
// push, an ignored token or an operator that finds fewer than two entries
// goes straight to the finish state; add, subtract, multiply and xor make
// two stack reads through the single RAM read port, an ALU step and a
// write-back, and divide and remainder also run the shared ALU's
// one-bit-per-cycle divider (32 steps plus sign fix) unless the divisor is
// zero. A token marked last reads the top of stack in the finish state and
// then waits until the output register is free; the result beat then stays in
// the output register while further tokens are accepted. The stack RAM needs no clearing after reset.
`default_nettype none

module postfix_stack_evaluator #(
  parameter int STACK_DEPTH = pse_pkg::DEFAULT_STACK_DEPTH
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [pse_pkg::OPC_W-1:0]           opcode,
  input  wire logic [pse_pkg::NUM_W-1:0]           number_value,
  input  wire logic                                last_token,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [pse_pkg::DATA_W-1:0]        result_value,
  output logic [pse_pkg::STATUS_W-1:0]             status,
  output logic [pse_pkg::DEPTH_W-1:0]              final_depth
);

  localparam int AW  = $clog2(STACK_DEPTH);
  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam logic [SPW-1:0] SP_FULL = SPW'(STACK_DEPTH);
  localparam logic [SPW-1:0] SP_TWO  = SPW'(2);

  typedef enum logic [2:0] {
    S_IDLE, S_RD1, S_RD2, S_RD3, S_EXEC, S_FIN, S_EMIT
  } state_t;

  state_t            state;
  logic [SPW-1:0]    sp;
  pse_pkg::status_t  err;
  pse_pkg::opcode_t  tok_op;
  logic              tok_last;
  pse_pkg::word_t    rhs_q;

  logic [SPW-1:0]    sp_m1;
  logic [SPW-1:0]    sp_m2;
  logic              out_free;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  pse_pkg::word_t    mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  pse_pkg::word_t    mem_rdata;
  logic              alu_start;
  pse_pkg::alu_rsp_t alu_rsp;

  assign sp_m1     = sp - 1'b1;
  assign sp_m2     = sp - SP_TWO;
  assign in_ready  = (state == S_IDLE) && !rst;
  assign out_free  = !out_valid || out_ready;
  assign alu_start = (state == S_RD3);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = sp[AW-1:0];
    mem_wdata = {1'b0, number_value};
    mem_re    = 1'b0;
    mem_raddr = sp_m1[AW-1:0];
    unique case (state)
      S_IDLE: mem_we = in_valid && (opcode == pse_pkg::OP_PUSH) && (sp != SP_FULL);
      S_RD1:  mem_re = 1'b1;
      S_RD2: begin
        mem_re    = 1'b1;
        mem_raddr = sp_m2[AW-1:0];
      end
      S_EXEC: begin
        if (alu_rsp.done) begin
          mem_we    = 1'b1;
          mem_waddr = sp_m2[AW-1:0];
          mem_wdata = alu_rsp.result;
        end
      end
      S_FIN:  mem_re = tok_last && (sp != '0);
      default: ;
    endcase
  end

  pse_stack #(
    .DEPTH (STACK_DEPTH),
    .AW    (AW)
  ) u_stack (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Left operand comes straight from the RAM read register.
  pse_alu u_alu (
    .clk   (clk),
    .rst   (rst),
    .start (alu_start),
    .op    (tok_op),
    .lhs   (mem_rdata),
    .rhs   (rhs_q),
    .rsp   (alu_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      sp        <= '0;
      err       <= pse_pkg::ST_OK;
      out_valid <= 1'b0;
    end else begin
      // Load a new beat when the register frees up, drop it once taken.
      if ((state == S_EMIT) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            tok_op   <= opcode;
            tok_last <= last_token;
            state    <= S_FIN;
            unique case (opcode) inside
              pse_pkg::OP_PUSH: begin
                // Drop the push on a full stack.
                if (sp == SP_FULL) begin
                  if (err == pse_pkg::ST_OK) err <= pse_pkg::ST_OVER;
                end else begin
                  sp <= sp + 1'b1;
                end
              end
              pse_pkg::OP_ADD, pse_pkg::OP_SUB, pse_pkg::OP_DIV,
              pse_pkg::OP_MUL, pse_pkg::OP_REM, pse_pkg::OP_XOR: begin
                if (sp < SP_TWO) begin
                  if (err == pse_pkg::ST_OK) err <= pse_pkg::ST_UNDER;
                end else begin
                  state <= S_RD1;
                end
              end
              default: ;
            endcase
          end
        end
        S_RD1: state <= S_RD2;
        S_RD2: begin
          rhs_q <= mem_rdata;
          state <= S_RD3;
        end
        S_RD3: state <= S_EXEC;
        S_EXEC: begin
          if (alu_rsp.done) begin
            sp <= sp_m1;
            if (alu_rsp.div_zero && (err == pse_pkg::ST_OK)) begin
              err <= pse_pkg::ST_DIVZ;
            end
            state <= S_FIN;
          end
        end
        S_FIN: state <= tok_last ? S_EMIT : S_IDLE;
        S_EMIT: begin
          if (out_free) begin
            result_value <= (sp != '0) ? mem_rdata : '0;
            status       <= err;
            final_depth  <= pse_pkg::DEPTH_W'(sp);
            sp           <= '0;
            err          <= pse_pkg::ST_OK;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_sp_bound: assert property (@(posedge clk) disable iff (rst)
    sp <= SP_FULL)
    else $error("stack pointer beyond stack depth");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (opcode == pse_pkg::OP_PUSH) && (sp != SP_FULL))
    |=> (sp == $past(sp) + 1'b1))
    else $error("push did not advance stack pointer");

  a_emit_clears: assert property (@(posedge clk) disable iff (rst)
    ((state == S_EMIT) && out_free)
    |=> (out_valid && (sp == '0) && (err == pse_pkg::ST_OK)))
    else $error("emit did not load output and empty the stack");

  a_alu_in_exec: assert property (@(posedge clk) disable iff (rst)
    alu_rsp.done |-> (state == S_EXEC))
    else $error("alu finished outside execute state");
`endif

endmodule

`default_nettype wire

// ===== rtl/pse_stack.sv =====
// ----------------------------------------------------------------------------
// pse_stack
// Operand stack storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module pse_stack #(
  parameter int DEPTH = pse_pkg::DEFAULT_STACK_DEPTH,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire pse_pkg::word_t wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output pse_pkg::word_t     rdata
);

  pse_pkg::word_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Hold read data until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/pse_alu.sv =====
// ----------------------------------------------------------------------------
// pse_alu
// Shared arithmetic unit: add, subtract, multiply and xor directly, signed
// divide and remainder by a restoring shift-subtract loop, one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pse_alu (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire pse_pkg::opcode_t op,
  input  wire pse_pkg::word_t   lhs,
  input  wire pse_pkg::word_t   rhs,
  output pse_pkg::alu_rsp_t     rsp
);

  localparam int W     = pse_pkg::DATA_W;
  localparam int CNT_W = $clog2(W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(W - 1);

  typedef enum logic [1:0] {A_IDLE, A_DIV, A_FIX} alu_state_t;

  alu_state_t       state;
  logic [CNT_W-1:0] cnt;
  pse_pkg::word_t   quo;
  pse_pkg::word_t   rem;
  pse_pkg::word_t   dvs;
  logic             neg_q;
  logic             neg_r;
  logic             is_rem;
  logic             done;
  logic             div_zero;
  pse_pkg::word_t   result;

  pse_pkg::word_t   lhs_mag;
  pse_pkg::word_t   rhs_mag;
  logic [W:0]       rem_sh;
  logic [W:0]       diff;

  assign lhs_mag = lhs[W-1] ? -lhs : lhs;
  assign rhs_mag = rhs[W-1] ? -rhs : rhs;
  assign rem_sh  = {rem, quo[W-1]};
  assign diff    = rem_sh - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= A_IDLE;
      done     <= 1'b0;
      div_zero <= 1'b0;
    end else begin
      unique case (state)
        A_IDLE: begin
          if (start) begin
            div_zero <= 1'b0;
            unique case (op) inside
              pse_pkg::OP_ADD: begin
                result <= lhs + rhs;
                done   <= 1'b1;
              end
              pse_pkg::OP_SUB: begin
                result <= lhs - rhs;
                done   <= 1'b1;
              end
              pse_pkg::OP_MUL: begin
                result <= lhs * rhs;
                done   <= 1'b1;
              end
              pse_pkg::OP_DIV, pse_pkg::OP_REM: begin
                if (rhs == '0) begin
                  result   <= '0;
                  div_zero <= 1'b1;
                  done     <= 1'b1;
                end else begin
                  quo    <= lhs_mag;
                  rem    <= '0;
                  dvs    <= rhs_mag;
                  neg_q  <= lhs[W-1] ^ rhs[W-1];
                  neg_r  <= lhs[W-1];
                  is_rem <= (op == pse_pkg::OP_REM);
                  cnt    <= '0;
                  done   <= 1'b0;
                  state  <= A_DIV;
                end
              end
              default: begin
                result <= lhs ^ rhs;
                done   <= 1'b1;
              end
            endcase
          end else begin
            done <= 1'b0;
          end
        end
        A_DIV: begin
          // Subtract when the shifted remainder covers the divisor.
          if (!diff[W]) begin
            rem <= diff[W-1:0];
            quo <= {quo[W-2:0], 1'b1};
          end else begin
            rem <= rem_sh[W-1:0];
            quo <= {quo[W-2:0], 1'b0};
          end
          cnt <= cnt + 1'b1;
          if (cnt == CNT_LAST) begin
            state <= A_FIX;
          end
        end
        A_FIX: begin
          // Quotient takes the xor of signs, remainder the dividend's sign.
          if (is_rem) begin
            result <= neg_r ? -rem : rem;
          end else begin
            result <= neg_q ? -quo : quo;
          end
          done  <= 1'b1;
          state <= A_IDLE;
        end
        default: begin
          done  <= 1'b0;
          state <= A_IDLE;
        end
      endcase
    end
  end

  assign rsp.done     = done;
  assign rsp.div_zero = div_zero;
  assign rsp.result   = result;

`ifndef SYNTHESIS
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("alu done held longer than one cycle");

  a_divz_zero: assert property (@(posedge clk) disable iff (rst)
    (done && div_zero) |-> (result == '0))
    else $error("divide by zero returned nonzero result");

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == A_DIV) |-> (dvs != '0))
    else $error("division loop running with zero divisor");
`endif

endmodule

`default_nettype wire

// ===== sim/postfix_stack_evaluator_tb.sv =====
// ----------------------------------------------------------------------------
// postfix_stack_evaluator_tb
// Self-checking bench for the postfix stack evaluator. A short table of
// directed tokens runs first (edge values, every operator, error cases), then
// random expressions: mostly well-formed ones with random operands, some deep
// stack fills and some token noise. Directed rows carry their own expected
// beats, a stack model predicts the rest, and a monitor compares each field.
// ----------------------------------------------------------------------------
`default_nettype none

module postfix_stack_evaluator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STACK_DEPTH  = pse_pkg::DEFAULT_STACK_DEPTH;
  localparam int CLK_HALF     = 10;
  localparam int ITEM_TARGET  = 1450;
  localparam int N_DIRECTED   = 27;
  localparam int LONG_HOLD    = 400;
  localparam int SETTLE_CYC   = 60;
  localparam longint TIMEOUT_NS = 64'd20_000_000;

  typedef logic [pse_pkg::NUM_W-1:0]   num_t;
  typedef logic [pse_pkg::DEPTH_W-1:0] depth_t;

  // Opcode 7 has no operation behind it; the block skips it.
  localparam pse_pkg::opcode_t OP_NONE = 3'd7;
  localparam num_t             NUM_MAX = '1;

  typedef struct packed {
    pse_pkg::opcode_t op;
    num_t             num;
    logic             last;
  } token_t;

  typedef struct packed {
    pse_pkg::word_t   value;
    pse_pkg::status_t status;
    depth_t           depth;
  } result_t;

  typedef struct packed {
    pse_pkg::opcode_t op;
    num_t             num;
    logic             last;
    logic             typed;
    result_t          want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  pse_pkg::opcode_t opcode = pse_pkg::OP_PUSH;
  num_t number_value = '0;
  logic last_token = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [pse_pkg::DATA_W-1:0] result_value;
  pse_pkg::status_t status;
  depth_t final_depth;

  postfix_stack_evaluator #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .opcode(opcode),
    .number_value(number_value),
    .last_token(last_token),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .result_value(result_value),
    .status(status),
    .final_depth(final_depth)
  );

  always #CLK_HALF clk = ~clk;

  // Predicted stack contents and sticky error of the expression in flight
  pse_pkg::word_t   calc_stack [STACK_DEPTH];
  int               calc_depth = 0;
  pse_pkg::status_t calc_err = pse_pkg::ST_OK;

  result_t  pending_results [$];
  token_t   pending_tokens [$];
  dir_row_t directed_rows [N_DIRECTED];

  int mismatch_count = 0;
  int sent_items = 0;
  bit quiet_phase = 1'b0;
  bit stall_request = 1'b0;

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("%0t ns ERROR: %s", $time, msg);
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet_phase || r < 70) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void note_error(input pse_pkg::status_t code);
    if (calc_err == pse_pkg::ST_OK) calc_err = code;
  endfunction

  // Apply one token to the predicted stack; a last token yields a result.
  task automatic evaluate_token(input token_t tok, output bit has, output result_t r);
    pse_pkg::word_t lhs;
    pse_pkg::word_t rhs;
    pse_pkg::word_t val;
    longint a;
    longint b;
    has = 1'b0;
    r = '0;
    if (tok.op == pse_pkg::OP_PUSH) begin
      if (calc_depth >= STACK_DEPTH) begin
        note_error(pse_pkg::ST_OVER);
      end else begin
        calc_stack[calc_depth] = {1'b0, tok.num};
        calc_depth++;
      end
    end else if (tok.op != OP_NONE) begin
      if (calc_depth < 2) begin
        note_error(pse_pkg::ST_UNDER);
      end else begin
        rhs = calc_stack[calc_depth-1];
        lhs = calc_stack[calc_depth-2];
        a = $signed(lhs);
        b = $signed(rhs);
        val = '0;
        case (tok.op)
          pse_pkg::OP_ADD: val = lhs + rhs;
          pse_pkg::OP_SUB: val = lhs - rhs;
          pse_pkg::OP_MUL: val = lhs * rhs;
          pse_pkg::OP_XOR: val = lhs ^ rhs;
          pse_pkg::OP_DIV, pse_pkg::OP_REM: begin
            // 64-bit math keeps the most negative value over minus one exact
            if (b == 0) note_error(pse_pkg::ST_DIVZ);
            else if (tok.op == pse_pkg::OP_DIV) val = pse_pkg::word_t'(a / b);
            else val = pse_pkg::word_t'(a % b);
          end
          default: val = '0;
        endcase
        calc_depth--;
        calc_stack[calc_depth-1] = val;
      end
    end
    if (tok.last) begin
      has = 1'b1;
      r.value = (calc_depth > 0) ? calc_stack[calc_depth-1] : '0;
      r.status = calc_err;
      r.depth = calc_depth[pse_pkg::DEPTH_W-1:0];
      calc_depth = 0;
      calc_err = pse_pkg::ST_OK;
    end
  endtask

  task automatic send_token(input token_t tok, input bit typed, input result_t want);
    int gap;
    bit has;
    result_t r;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    opcode <= tok.op;
    number_value <= tok.num;
    last_token <= tok.last;
    do @(posedge clk); while (!in_ready);
    evaluate_token(tok, has, r);
    if (has) pending_results.push_back(typed ? want : r);
    sent_items++;
  endtask

  task automatic add_token(input pse_pkg::opcode_t op, input num_t num);
    token_t t;
    t.op = op;
    t.num = num;
    t.last = 1'b0;
    pending_tokens.push_back(t);
  endtask

  task automatic flush_tokens(input bit mark_last);
    if (mark_last && pending_tokens.size() > 0)
      pending_tokens[pending_tokens.size()-1].last = 1'b1;
    while (pending_tokens.size() > 0) send_token(pending_tokens.pop_front(), 1'b0, '0);
  endtask

  // Drop valid and hold until every predicted beat has been seen.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic add_operand();
    case ($urandom_range(0, 9))
      0: add_token(pse_pkg::OP_PUSH, '0);
      1: add_token(pse_pkg::OP_PUSH, num_t'(1));
      2: add_token(pse_pkg::OP_PUSH, NUM_MAX);
      3: begin
        // minus one
        add_token(pse_pkg::OP_PUSH, '0);
        add_token(pse_pkg::OP_PUSH, num_t'(1));
        add_token(pse_pkg::OP_SUB, num_t'($urandom()));
      end
      4: begin
        // most negative value
        add_token(pse_pkg::OP_PUSH, '0);
        add_token(pse_pkg::OP_PUSH, NUM_MAX);
        add_token(pse_pkg::OP_SUB, '0);
        add_token(pse_pkg::OP_PUSH, num_t'(1));
        add_token(pse_pkg::OP_SUB, '0);
      end
      5, 6: add_token(pse_pkg::OP_PUSH, num_t'($urandom_range(0, 20)));
      default: add_token(pse_pkg::OP_PUSH, num_t'($urandom()));
    endcase
    if ($urandom_range(0, 19) == 0) add_token(OP_NONE, num_t'($urandom()));
  endtask

  task automatic gen_expression();
    int leaves;
    int placed;
    int depth;
    leaves = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
    placed = 0;
    depth = 0;
    while (placed < leaves || depth > 1) begin
      if (placed < leaves && (depth < 2 || $urandom_range(0, 1) == 1)) begin
        add_operand();
        placed++;
        depth++;
      end else begin
        add_token(pse_pkg::opcode_t'($urandom_range(pse_pkg::OP_ADD, pse_pkg::OP_XOR)),
                  num_t'($urandom()));
        depth--;
      end
    end
    flush_tokens(1'b1);
  endtask

  task automatic gen_deep_fill(input int pushes);
    repeat (pushes) add_token(pse_pkg::OP_PUSH, num_t'($urandom()));
    repeat ($urandom_range(0, 5))
      add_token(pse_pkg::opcode_t'($urandom_range(pse_pkg::OP_ADD, pse_pkg::OP_XOR)), '0);
    flush_tokens(1'b1);
  endtask

  task automatic gen_noise();
    token_t t;
    repeat ($urandom_range(1, 8)) begin
      t.op = pse_pkg::opcode_t'($urandom_range(0, 7));
      t.num = num_t'($urandom());
      t.last = ($urandom_range(0, 3) == 0);
      pending_tokens.push_back(t);
    end
    flush_tokens(1'b0);
  endtask

  // Hold the result side off while short expressions keep coming, so the
  // output register fills and the input stalls.
  task automatic run_backpressure();
    quiet_phase = 1'b1;
    stall_request = 1'b1;
    repeat (8) begin
      add_token(pse_pkg::OP_PUSH, num_t'($urandom()));
      add_token(pse_pkg::OP_PUSH, num_t'($urandom()));
      add_token(pse_pkg::opcode_t'($urandom_range(pse_pkg::OP_ADD, pse_pkg::OP_XOR)), '0);
      flush_tokens(1'b1);
    end
    quiet_phase = 1'b0;
    drain_results();
  endtask

  initial begin : result_sink
    int idle_left;
    int hold_left;
    idle_left = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (stall_request) begin
        stall_request = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (idle_left > 0) begin
        out_ready <= 1'b0;
        idle_left--;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) idle_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result beat with none pending: value %h status %0d depth %0d",
                                  result_value, status, final_depth));
      end else begin
        want = pending_results.pop_front();
        if (result_value !== want.value)
          report_mismatch($sformatf("result_value got %h want %h", result_value, want.value));
        if (status !== want.status)
          report_mismatch($sformatf("status got %0d want %0d", status, want.status));
        if (final_depth !== want.depth)
          report_mismatch($sformatf("final_depth got %0d want %0d", final_depth, want.depth));
      end
    end
  end

  initial begin : stimulus
    token_t tok;
    bit pressure_done;
    int kind;
    pressure_done = 1'b0;
    directed_rows = '{
      '{OP_NONE, '0,    1'b1, 1'b1, '{32'h0000_0000, pse_pkg::ST_OK,    7'd0}},
      '{pse_pkg::OP_ADD,  '0,            1'b1, 1'b1,
        '{32'h0000_0000, pse_pkg::ST_UNDER, 7'd0}},
      '{pse_pkg::OP_PUSH, NUM_MAX,       1'b0, 1'b0, '0},
      '{pse_pkg::OP_PUSH, NUM_MAX,       1'b0, 1'b0, '0},
      '{pse_pkg::OP_ADD,  '0,            1'b1, 1'b1,
        '{32'hFFFF_FFFE, pse_pkg::ST_OK,    7'd1}},
      '{pse_pkg::OP_PUSH, '0,            1'b0, 1'b0, '0},
      '{pse_pkg::OP_PUSH, 31'd1,         1'b0, 1'b0, '0},
      '{pse_pkg::OP_SUB,  '0,            1'b0, 1'b0, '0},
      '{pse_pkg::OP_PUSH, NUM_MAX,       1'b0, 1'b0, '0},
      '{pse_pkg::OP_SUB,  '0,            1'b0, 1'b0, '0},
      '{pse_pkg::OP_PUSH, '0,            1'b0, 1'b0, '0},
      '{pse_pkg::OP_PUSH, 31'd1,         1'b0, 1'b0, '0},
      '{pse_pkg::OP_SUB,  '0,            1'b0, 1'b0, '0},
      '{pse_pkg::OP_DIV,  '0,            1'b1, 1'b1,
        '{32'h8000_0000, pse_pkg::ST_OK,    7'd1}},
      '{pse_pkg::OP_PUSH, 31'd7,         1'b0, 1'b0, '0},
      '{pse_pkg::OP_PUSH, '0,            1'b0, 1'b0, '0},
      '{pse_pkg::OP_REM,  '0,            1'b0, 1'b0, '0},
      '{pse_pkg::OP_PUSH, 31'd5,         1'b0, 1'b0, '0},
      '{pse_pkg::OP_XOR,  '0,            1'b1, 1'b1,
        '{32'h0000_0005, pse_pkg::ST_DIVZ,  7'd1}},
      '{pse_pkg::OP_PUSH, 31'd9,         1'b0, 1'b0, '0},
      '{pse_pkg::OP_DIV,  '0,            1'b0, 1'b0, '0},
      '{pse_pkg::OP_PUSH, '0,            1'b0, 1'b0, '0},
      '{pse_pkg::OP_DIV,  '0,            1'b1, 1'b1,
        '{32'h0000_0000, pse_pkg::ST_UNDER, 7'd1}},
      '{pse_pkg::OP_PUSH, 31'h4000_0003, 1'b0, 1'b0, '0},
      '{pse_pkg::OP_PUSH, 31'd4,         1'b0, 1'b0, '0},
      '{OP_NONE,          31'h5555_5555, 1'b0, 1'b0, '0},
      '{pse_pkg::OP_MUL,  '0,            1'b1, 1'b1,
        '{32'h0000_000C, pse_pkg::ST_OK,    7'd1}}
    };
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_DIRECTED; i++) begin
      tok.op = directed_rows[i].op;
      tok.num = directed_rows[i].num;
      tok.last = directed_rows[i].last;
      send_token(tok, directed_rows[i].typed, directed_rows[i].want);
    end

    // Push past the top of the stack at least once.
    gen_deep_fill(66);

    while (sent_items < ITEM_TARGET) begin
      if (!pressure_done && sent_items >= ITEM_TARGET / 2) begin
        run_backpressure();
        pressure_done = 1'b1;
      end
      if ($urandom_range(0, 24) == 0) quiet_phase = !quiet_phase;
      kind = $urandom_range(0, 99);
      if (kind < 6) gen_deep_fill($urandom_range(60, 68));
      else if (kind < 20) gen_noise();
      else gen_expression();
      if ($urandom_range(0, 29) == 0) drain_results();
    end

    // Close any expression that noise left open.
    add_token(OP_NONE, '0);
    flush_tokens(1'b1);
    drain_results();
    repeat (SETTLE_CYC) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("postfix_stack_evaluator verification clean");
    end else begin
      $display("postfix_stack_evaluator verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("postfix_stack_evaluator verification failed");
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/pse_pkg.sv
rtl/pse_stack.sv
rtl/pse_alu.sv
rtl/postfix_stack_evaluator.sv
sim/postfix_stack_evaluator_tb.sv
